>>> rtl/fltpw_pkg.sv
// Package for the four-level page table walker: item types, codes and helpers.
package fltpw_pkg;

    localparam int ADDR_W              = 52;
    localparam int VIRT_W              = 48;
    localparam int ENTRY_W             = 64;
    localparam int PHYS_ADDR_BITS_DEF  = 52;

    localparam logic       CMD_START    = 1'b0;
    localparam logic       CMD_RESPONSE = 1'b1;

    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_HUGE_BIT    = 7;

    localparam logic [ADDR_W-1:0] GIB_BASE_MASK = 52'hF_FFFF_C000_0000;
    localparam logic [ADDR_W-1:0] MIB_BASE_MASK = 52'hF_FFFF_FFE0_0000;

    typedef struct packed {
        logic              command;
        logic [VIRT_W-1:0] virt_addr;
        logic [ENTRY_W-1:0] entry_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] read_addr;
        logic [ADDR_W-1:0] xlat_addr;
        logic              fault;
    } out_item_t;

    typedef struct packed {
        logic              walking;
        logic [1:0]        level;
        logic [VIRT_W-1:0] held_virt;
    } walk_state_t;

    // 9-bit table index of a virtual address at a given level
    function automatic logic [8:0] level_index(input logic [VIRT_W-1:0] va,
                                               input logic [1:0] level);
        logic [8:0] idx;
        case (level)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/fltpw_step.sv
// Per-item walk logic: result item and next walk state from one input item.
module fltpw_step
    import fltpw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
)
(
    input  in_item_t          item,
    input  walk_state_t       state,
    input  logic [ADDR_W-1:0] root_base,
    output out_item_t         result,
    output walk_state_t       state_next
);

    localparam logic [ADDR_W-1:0] LIM =
        ADDR_W'((64'(1) << PHYS_ADDR_BITS) - 64'(1));
    localparam logic [ADDR_W-1:0] PAGE_MASK = LIM & {{(ADDR_W-12){1'b1}}, 12'h000};

    logic [ADDR_W-1:0] entry_addr;
    logic [1:0]        level_inc;
    logic [ADDR_W-1:0] pa_base;
    logic [ADDR_W-1:0] pa_off;
    logic [ADDR_W-1:0] pa_sum;

    assign entry_addr = item.entry_data[ADDR_W-1:0];
    assign level_inc  = state.level + 2'd1;
    assign pa_sum     = (pa_base + pa_off) & LIM;

    always_comb
    begin
        case (state.level)
            2'd0:
            begin
                pa_base = entry_addr & PAGE_MASK;
                pa_off  = ADDR_W'(state.held_virt[38:0]);
            end
            2'd1:
            begin
                pa_base = entry_addr & GIB_BASE_MASK & LIM;
                pa_off  = ADDR_W'(state.held_virt[29:0]);
            end
            2'd2:
            begin
                pa_base = entry_addr & MIB_BASE_MASK & LIM;
                pa_off  = ADDR_W'(state.held_virt[20:0]);
            end
            default:
            begin
                pa_base = entry_addr & PAGE_MASK;
                pa_off  = ADDR_W'(state.held_virt[11:0]);
            end
        endcase
    end

    always_comb
    begin
        result     = '0;
        state_next = state;
        if (item.command == CMD_START)
        begin
            if (state.walking)
            begin
                result.kind = KIND_IGNORED;
            end
            else
            begin
                state_next.walking   = 1'b1;
                state_next.level     = 2'd0;
                state_next.held_virt = item.virt_addr;
                result.kind          = KIND_READ;
                // index*8 stays below 4 KiB, so this never carries into the base
                result.read_addr = (root_base & PAGE_MASK)
                    + ADDR_W'({level_index(item.virt_addr, 2'd0), 3'b000});
            end
        end
        else if (!state.walking)
        begin
            result.kind = KIND_IGNORED;
        end
        else if (!item.entry_data[ENTRY_PRESENT_BIT])
        begin
            state_next.walking = 1'b0;
            state_next.level   = 2'd0;
            result.kind        = KIND_DONE;
            result.fault       = 1'b1;
        end
        else if (state.level == 2'd3 || item.entry_data[ENTRY_HUGE_BIT])
        begin
            state_next.walking = 1'b0;
            state_next.level   = 2'd0;
            result.kind        = KIND_DONE;
            result.xlat_addr   = pa_sum;
        end
        else
        begin
            state_next.level = level_inc;
            result.kind      = KIND_READ;
            result.read_addr = (entry_addr & PAGE_MASK)
                + ADDR_W'({level_index(state.held_virt, level_inc), 3'b000});
        end
    end

endmodule

>>> rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker: state, root register, result register.
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while out_ready is high; the result register refills in the cycle it is taken.
// Reset (rst_n low, asynchronous): idle, top level, held address and root base zero,
// no result pending.
module four_level_page_table_walker
    import fltpw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    walk_state_t       state_reg;
    walk_state_t       state_next;
    logic [ADDR_W-1:0] root_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    out_item_t         result;
    logic              accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    fltpw_step #(
        .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
    ) u_step (
        .item      (in_data),
        .state     (state_reg),
        .root_base (root_reg),
        .result    (result),
        .state_next(state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                root_reg <= cfg_data;
            end
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

>>> verif/tb_four_level_page_table_walker.sv
// Testbench for the four-level page table walker: directed and random walks checked against a predictor.
module tb_four_level_page_table_walker;
    import fltpw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [ADDR_W-1:0] PA_LIMIT =
        ADDR_W'((64'd1 << PHYS_ADDR_BITS_DEF) - 64'd1);
    localparam logic [ADDR_W-1:0] PAGE_MASK = PA_LIMIT & ~52'hFFF;
    localparam logic [ADDR_W-1:0] ROOT_MAX = {ADDR_W{1'b1}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_item_t          in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data = '0;

    // walker state as predicted from the accepted items
    logic [ADDR_W-1:0] root_base = '0;
    logic              walking = 1'b0;
    logic [1:0]        walk_level = 2'd0;
    logic [VIRT_W-1:0] held_va = '0;

    out_item_t expected_results[$];
    int        errors = 0;
    int        cycle_count = 0;
    bit        steady = 1'b0;

    four_level_page_table_walker #(
        .PHYS_ADDR_BITS(PHYS_ADDR_BITS_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        errors++;
    endtask

    // byte offset of the entry for va in the table at the given level
    function automatic logic [ADDR_W-1:0] table_slot(input logic [VIRT_W-1:0] va,
                                                     input int level);
        logic [8:0] idx;
        idx = 9'(va >> (39 - 9 * level));
        return ADDR_W'({idx, 3'b000});
    endfunction

    function automatic out_item_t predict_walk(input in_item_t item);
        out_item_t         res;
        logic [ADDR_W-1:0] entry_lo;
        logic [ADDR_W-1:0] frame;
        logic [ADDR_W-1:0] offset;
        res = '0;
        entry_lo = item.entry_data[ADDR_W-1:0];
        if (item.command == CMD_START)
        begin
            if (walking)
                res.kind = KIND_IGNORED;
            else
            begin
                held_va = item.virt_addr;
                walk_level = 2'd0;
                walking = 1'b1;
                res.kind = KIND_READ;
                res.read_addr = (root_base & PAGE_MASK) + table_slot(held_va, 0);
            end
        end
        else if (!walking)
            res.kind = KIND_IGNORED;
        else if (!item.entry_data[ENTRY_PRESENT_BIT])
        begin
            walking = 1'b0;
            walk_level = 2'd0;
            res.kind = KIND_DONE;
            res.fault = 1'b1;
        end
        else if (walk_level == 2'd3 || item.entry_data[ENTRY_HUGE_BIT])
        begin
            case (walk_level)
                2'd0:
                begin
                    frame = entry_lo & PAGE_MASK;
                    offset = ADDR_W'(held_va[38:0]);
                end
                2'd1:
                begin
                    frame = entry_lo & GIB_BASE_MASK & PA_LIMIT;
                    offset = ADDR_W'(held_va[29:0]);
                end
                2'd2:
                begin
                    frame = entry_lo & MIB_BASE_MASK & PA_LIMIT;
                    offset = ADDR_W'(held_va[20:0]);
                end
                default:
                begin
                    frame = entry_lo & PAGE_MASK;
                    offset = ADDR_W'(held_va[11:0]);
                end
            endcase
            walking = 1'b0;
            walk_level = 2'd0;
            res.kind = KIND_DONE;
            res.xlat_addr = (frame + offset) & PA_LIMIT;
        end
        else
        begin
            walk_level = walk_level + 2'd1;
            res.kind = KIND_READ;
            res.read_addr = (entry_lo & PAGE_MASK) + table_slot(held_va, int'(walk_level));
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected item kind", 64'(out_data.kind), '0);
            else
            begin
                want = expected_results.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
                if (out_data.read_addr !== want.read_addr)
                    report_mismatch("read_addr", 64'(out_data.read_addr),
                                    64'(want.read_addr));
                if (out_data.xlat_addr !== want.xlat_addr)
                    report_mismatch("xlat_addr", 64'(out_data.xlat_addr),
                                    64'(want.xlat_addr));
                if (out_data.fault !== want.fault)
                    report_mismatch("fault", 64'(out_data.fault), 64'(want.fault));
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // unused fields carry random bits too
    function automatic in_item_t start_cmd(input logic [VIRT_W-1:0] va);
        in_item_t item;
        item.command = CMD_START;
        item.virt_addr = va;
        item.entry_data = rand64();
        return item;
    endfunction

    function automatic in_item_t resp_cmd(input logic [ENTRY_W-1:0] entry);
        in_item_t item;
        item.command = CMD_RESPONSE;
        item.virt_addr = VIRT_W'(rand64());
        item.entry_data = entry;
        return item;
    endfunction

    task automatic send_item(input in_item_t item);
        while (!steady && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(predict_walk(item));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_root(input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        root_base = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // zero and all-ones root, huge top-level page with address wrap
    task automatic test_root_extremes();
        send_item(start_cmd('0));
        send_item(resp_cmd(64'h1));
        send_item(resp_cmd({ENTRY_W{1'b1}}));
        drain();
        set_root(ROOT_MAX);
        send_item(start_cmd({VIRT_W{1'b1}}));
        send_item(resp_cmd({ENTRY_W{1'b1}}));
        drain();
    endtask

    task automatic test_fault_and_ignored();
        send_item(resp_cmd(rand64()));
        send_item(start_cmd(VIRT_W'(rand64())));
        send_item(start_cmd(VIRT_W'(rand64())));
        send_item(resp_cmd(64'hFFFF_FFFF_FFFF_FFFE));
        drain();
    endtask

    // full walks: last level with and without the huge bit, 2 MiB huge page
    task automatic test_full_walks();
        set_root(52'h0_1234_5678_9ABC);
        send_item(start_cmd(48'hA5A5_5A5A_F00F));
        send_item(resp_cmd(64'hFFFF_FFFF_FFFF_FF7F));
        send_item(resp_cmd(64'h8000_0000_0000_1001));
        send_item(resp_cmd(64'h000F_FFFF_FFFF_F003));
        send_item(resp_cmd({ENTRY_W{1'b1}}));
        send_item(start_cmd(48'hFFFF_FFFF_FFFF));
        send_item(resp_cmd(64'h0000_0000_0000_2001));
        send_item(resp_cmd(64'h0000_0000_0000_3001));
        send_item(resp_cmd(64'hFFFF_FFFF_FFFF_FFFF));
        send_item(start_cmd(48'h0000_0000_0FFF));
        send_item(resp_cmd(64'h7FF0_0000_0000_0001));
        send_item(resp_cmd(64'h000A_BCDE_F000_0001));
        send_item(resp_cmd(64'h0005_5555_5555_5001));
        send_item(resp_cmd(64'h000F_FFFF_FFFF_F07F));
        drain();
    endtask

    // mostly complete walks with random content, some stray and dropped items
    task automatic test_random_walks(input int n_items, input logic [ADDR_W-1:0] root);
        int          sent;
        logic [63:0] entry;
        set_root(root);
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_item(resp_cmd(rand64()));
                sent++;
            end
            send_item(start_cmd(VIRT_W'(rand64())));
            sent++;
            while (walking)
            begin
                if ($urandom_range(99) < 8)
                begin
                    send_item(start_cmd(VIRT_W'(rand64())));
                    sent++;
                end
                // leave the walk open now and then; later starts are then ignored
                if ($urandom_range(99) < 3)
                    break;
                entry = rand64();
                entry[ENTRY_PRESENT_BIT] = ($urandom_range(99) < 90);
                entry[ENTRY_HUGE_BIT] = (walk_level == 2'd3) ? 1'($urandom_range(1))
                                                              : ($urandom_range(99) < 20);
                send_item(resp_cmd(entry));
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_root_extremes();
        test_fault_and_ignored();
        test_full_walks();
        test_random_walks(130, ADDR_W'(rand64()));
        steady = 1'b1;
        test_random_walks(130, '0);
        steady = 1'b0;
        test_random_walks(130, ROOT_MAX);
        test_random_walks(130, ADDR_W'(rand64()));
        if (expected_results.size() != 0)
            report_mismatch("results missing", 64'(expected_results.size()), '0);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
